@@ rtl/sce_pkg.sv @@
package sce_pkg;

   // Input transaction payload.
   typedef struct packed {
      logic               command;
      logic [7:0]         row_index;
      logic [5:0]         col_index;
      logic signed [31:0] write_value;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] read_value;
      logic [8:0]         nonzero_count;
   } rsp_type;

   // Command codes.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Result status codes.
   localparam logic [2:0] STAT_READ_ZERO   = 3'd0;
   localparam logic [2:0] STAT_READ_FOUND  = 3'd1;
   localparam logic [2:0] STAT_UNCHANGED   = 3'd2;
   localparam logic [2:0] STAT_OVERWRITTEN = 3'd3;
   localparam logic [2:0] STAT_INSERTED    = 3'd4;
   localparam logic [2:0] STAT_REMOVED     = 3'd5;
   localparam logic [2:0] STAT_RANGE       = 3'd6;
   localparam logic [2:0] STAT_FULL        = 3'd7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [1:0] CSR_COLS_IN_USE = 2'd1;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // Rewrite applied to the chain for the rest of a pass.
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_OVERWRITE,
      ACT_INSERT,
      ACT_REMOVE
   } action_type;

endpackage

@@ rtl/sparse_csc_element_store.sv @@
// Sparse matrix element store in compressed sparse column order.
// Requests arrive on the req_ channel (read or write of one element at row, column)
// and each produces exactly one result transaction on the rsp_ channel with a
// status, the old or read value and the number of stored nonzeros.
// Entries live in a circular chain of MAX_NONZEROS cells ordered by column, then row.
// Every request except an out-of-range one rotates the whole chain once, one cell
// per cycle; the entry leaving the tail is compared with the addressed key, and an
// overwrite, an insertion (through a one-entry carry) or a removal (by feeding from
// the next cell) is folded into the stream fed back to the head.
// Out-of-range requests skip the rotation and go straight to the done state; one
// request is in work at a time, so a new request is taken only after the last one
// has left the done state.
// The result sits in an output register; a new request is taken while it waits,
// but a finished request holds in the done state until the register is free.
// Reset empties the store, sets rows_in_use to 256 and cols_in_use to 64; the cell
// contents are not cleared. Configuration writes are always accepted.
module sparse_csc_element_store
   import sce_pkg::*;
#(
   parameter int MAX_NONZEROS = 256,
   parameter int MAX_ROWS     = 256,
   parameter int MAX_COLS     = 64,
   parameter int VALUE_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata
);

   localparam int CW = $clog2(MAX_NONZEROS + 1);
   localparam int SW = $clog2(MAX_NONZEROS);
   localparam logic [SW-1:0] LAST_STEP = SW'(MAX_NONZEROS - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_NONZEROS);

   // Chain wiring.
   logic [VALUE_BITS-1:0] val_q [MAX_NONZEROS];
   logic [7:0]            row_q [MAX_NONZEROS];
   logic [5:0]            col_q [MAX_NONZEROS];
   logic [VALUE_BITS-1:0] feed_val;
   logic [7:0]            feed_row;
   logic [5:0]            feed_col;
   logic                  shift_en;

   // Control and payload registers.
   state_type             state_ff, state_in;
   action_type            mode_ff;
   logic                  done_ff;
   logic [SW-1:0]         step_ff;
   logic [CW-1:0]         count_ff, new_count_ff;
   req_type               req_ff;
   logic [VALUE_BITS-1:0] wext_ff;
   logic [VALUE_BITS-1:0] carry_val_ff;
   logic [7:0]            carry_row_ff;
   logic [5:0]            carry_col_ff;
   rsp_type               result_ff, rsp_ff;
   logic                  rsp_valid_ff;
   logic [8:0]            rows_ff;
   logic [6:0]            cols_ff;

   logic                  req_fire, load_rsp, out_of_range;
   logic                  last, entry_valid, hit, found;
   logic [13:0]           key_tail, key_req;
   logic [VALUE_BITS-1:0] old_val;
   logic [63:0]           old_wide;
   action_type            act;
   logic [2:0]            hit_status;
   logic [31:0]           hit_value;
   logic [CW-1:0]         hit_count;
   int unsigned           row_limit, col_limit;

   // Cell chain: cell 0 takes the feed, the last cell is the tail.
   for (genvar i = 0; i < MAX_NONZEROS; i++) begin : g_cell
      if (i == 0) begin : g_head
         sce_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock(clock), .shift_en(shift_en),
            .val_d(feed_val), .row_d(feed_row), .col_d(feed_col),
            .val_q(val_q[i]), .row_q(row_q[i]), .col_q(col_q[i])
         );
      end else begin : g_body
         sce_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock(clock), .shift_en(shift_en),
            .val_d(val_q[i-1]), .row_d(row_q[i-1]), .col_d(col_q[i-1]),
            .val_q(val_q[i]), .row_q(row_q[i]), .col_q(col_q[i])
         );
      end
   end

   // Range check against the configured limits, capped at the build sizes.
   always_comb begin
      row_limit = (32'(rows_ff) > MAX_ROWS) ? MAX_ROWS : 32'(rows_ff);
      col_limit = (32'(cols_ff) > MAX_COLS) ? MAX_COLS : 32'(cols_ff);
      out_of_range = (32'(req_data.row_index) >= row_limit) ||
                     (32'(req_data.col_index) >= col_limit);
   end

   // Compare the entry leaving the tail with the addressed key.
   always_comb begin
      last        = (step_ff == LAST_STEP);
      entry_valid = CW'(step_ff) < count_ff;
      key_tail    = {col_q[MAX_NONZEROS-1], row_q[MAX_NONZEROS-1]};
      key_req     = {req_ff.col_index, req_ff.row_index};
      hit         = (state_ff == S_SCAN) && !done_ff &&
                    (!entry_valid || (key_tail >= key_req) || last);
      found       = entry_valid && (key_tail == key_req);
      old_val     = found ? val_q[MAX_NONZEROS-1] : '0;
      old_wide    = 64'(old_val);
   end

   // Decide what the request does once its sorted place is reached.
   always_comb begin
      act        = ACT_NONE;
      hit_status = STAT_UNCHANGED;
      hit_value  = old_wide[31:0];
      hit_count  = count_ff;
      if (req_ff.command == CMD_READ) begin
         hit_status = found ? STAT_READ_FOUND : STAT_READ_ZERO;
      end else begin
         priority if (wext_ff == old_val) begin
            hit_status = STAT_UNCHANGED;
         end else if (found && (wext_ff != '0)) begin
            act        = ACT_OVERWRITE;
            hit_status = STAT_OVERWRITTEN;
         end else if (found) begin
            act        = ACT_REMOVE;
            hit_status = STAT_REMOVED;
            hit_count  = count_ff - 1'b1;
         end else if (count_ff >= FULL_COUNT) begin
            hit_status = STAT_FULL;
            hit_value  = '0;
         end else begin
            act        = ACT_INSERT;
            hit_status = STAT_INSERTED;
            hit_value  = '0;
            hit_count  = count_ff + 1'b1;
         end
      end
   end

   // Stream fed back to the head of the chain.
   always_comb begin
      feed_val = val_q[MAX_NONZEROS-1];
      feed_row = row_q[MAX_NONZEROS-1];
      feed_col = col_q[MAX_NONZEROS-1];
      if (hit) begin
         unique case (act)
            ACT_OVERWRITE: feed_val = wext_ff;
            ACT_INSERT: begin
               feed_val = wext_ff;
               feed_row = req_ff.row_index;
               feed_col = req_ff.col_index;
            end
            ACT_REMOVE: begin
               feed_val = val_q[MAX_NONZEROS-2];
               feed_row = row_q[MAX_NONZEROS-2];
               feed_col = col_q[MAX_NONZEROS-2];
            end
            default: ;
         endcase
      end else if (done_ff) begin
         unique case (mode_ff)
            ACT_INSERT: begin
               feed_val = carry_val_ff;
               feed_row = carry_row_ff;
               feed_col = carry_col_ff;
            end
            ACT_REMOVE: begin
               feed_val = val_q[MAX_NONZEROS-2];
               feed_row = row_q[MAX_NONZEROS-2];
               feed_col = col_q[MAX_NONZEROS-2];
            end
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = out_of_range ? S_DONE : S_SCAN;
         S_SCAN: if (last) state_in = S_DONE;
         S_DONE: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      shift_en  = (state_ff == S_SCAN);
      load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_fire = req_valid && req_ready;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= ACT_NONE;
         done_ff      <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 9'd256;
         cols_ff      <= 7'd64;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            step_ff <= '0;
            done_ff <= 1'b0;
            mode_ff <= ACT_NONE;
         end else if (state_ff == S_SCAN) begin
            step_ff <= step_ff + 1'b1;
            if (hit) begin
               done_ff <= 1'b1;
               mode_ff <= act;
            end
            if (last) count_ff <= hit ? hit_count : new_count_ff;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROWS_IN_USE: rows_ff <= csr_wdata;
               CSR_COLS_IN_USE: cols_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      carry_val_ff <= val_q[MAX_NONZEROS-1];
      carry_row_ff <= row_q[MAX_NONZEROS-1];
      carry_col_ff <= col_q[MAX_NONZEROS-1];
      if (req_fire) begin
         req_ff       <= req_data;
         wext_ff      <= VALUE_BITS'(req_data.write_value);
         new_count_ff <= count_ff;
         result_ff    <= '{status: STAT_RANGE, read_value: '0,
                           nonzero_count: 9'(count_ff)};
      end else if (hit) begin
         new_count_ff <= hit_count;
         result_ff    <= '{status: hit_status, read_value: hit_value,
                           nonzero_count: 9'(hit_count)};
      end
      if (load_rsp) rsp_ff <= result_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

`ifndef NO_ASSERTIONS
   // The store never holds more entries than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // A pass always reaches its decision by the last step.
   a_decided: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && last) |=> done_ff)
      else $error("scan finished without a decision");

   // The entry count changes only at the end of a pass.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_SCAN && last) |=> $stable(count_ff))
      else $error("entry count changed mid pass");

   // A pass ends in the done state.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && last) |=> state_ff == S_DONE)
      else $error("scan did not end in done state");
`endif

endmodule

@@ rtl/sce_cell.sv @@
module sce_cell
   import sce_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [VALUE_BITS-1:0] val_d,
   input  logic [7:0]            row_d,
   input  logic [5:0]            col_d,
   output logic [VALUE_BITS-1:0] val_q,
   output logic [7:0]            row_q,
   output logic [5:0]            col_q
);

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [7:0]            row_ff, row_in;
   logic [5:0]            col_ff, col_in;

   // Take the neighbor's entry on a shift, otherwise hold.
   always_comb begin
      val_in = shift_en ? val_d : val_ff;
      row_in = shift_en ? row_d : row_ff;
      col_in = shift_en ? col_d : col_ff;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      row_ff <= row_in;
      col_ff <= col_in;
   end

   assign val_q = val_ff;
   assign row_q = row_ff;
   assign col_q = col_ff;

endmodule
